// ===== hdl/bba_pkg.sv =====
package bba_pkg;

	// field widths
	localparam int OFS_W  = 30;
	localparam int BB_W   = 21;
	localparam int LIM_W  = 11;
	localparam int SIG_W  = 8;
	localparam int ACT_W  = 2;
	localparam int ST_W   = 3;
	localparam int CNT_W  = 11;
	localparam int CFG_W  = 21;
	localparam int CFGA_W = 2;

	// default geometry
	localparam int CAPACITY_DEF  = 1024;
	localparam int WORD_BITS_DEF = 64;

	// register reset values
	localparam logic [BB_W-1:0]  BLOCK_BYTES_RST = BB_W'(4096);
	localparam logic [LIM_W-1:0] BLOCK_LIMIT_RST = LIM_W'(1024);
	localparam logic [LIM_W-1:0] RESERVED_RST    = LIM_W'(1);

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [ACT_W-1:0] {
		ACT_ALLOC  = 2'd0,
		ACT_FREE   = 2'd1,
		ACT_FORMAT = 2'd2
	} action_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK      = 3'd0,
		ST_OOM     = 3'd1,
		ST_BADSIG  = 3'd2,
		ST_BADID   = 3'd3,
		ST_IGNORED = 3'd4
	} status_t;

	typedef enum logic [CFGA_W-1:0] {
		REG_BLOCK_BYTES = 2'd0,
		REG_BLOCK_LIMIT = 2'd1,
		REG_RESERVED    = 2'd2
	} reg_idx_t;

	// divider request / response
	typedef struct packed {
		logic             start;
		logic [OFS_W-1:0] dividend;
		logic [BB_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [OFS_W-1:0] quotient;
		logic [BB_W-1:0]  remainder;
	} div_rsp_t;

endpackage

// ===== hdl/bitmap_block_allocator.sv =====
// First-fit block allocator over a free bitmap (set bit = free block).
// Requests enter on in_valid/in_ready, one at a time; each gives exactly one
// result on out_valid/out_ready. A result waits in an output register, so the
// next request is taken while the previous result is still unread; a request
// only stalls at its end if the output register is still full.
// Steps from acceptance to result (output register empty):
//   allocate: bitmap words are scanned from word 0 until a free bit is found;
//             one word is read per cycle, then the offset is multiplied.
//             Out of memory answers once all NWORDS words are scanned.
//   free:     the block id comes from a bit-serial divider (30 steps), the
//             word/bit position from a reciprocal multiply.
//             An id out of range answers after the divide, rejected handles without it.
//   format:   all NWORDS words are rewritten, one bitmap word written per cycle.
// After reset the block formats the bitmap with the reset register values
// while holding in_ready low; no result is produced for it.
// Configuration writes (cfg_we) take effect at once and should happen only
// while idle; limits are latched at the start of each format.
module bitmap_block_allocator import bba_pkg::*; #(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFGA_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [ACT_W-1:0]  action,
	input  logic [SIG_W-1:0]  caller_signature,
	input  logic [SIG_W-1:0]  handle_signature,
	input  logic [OFS_W-1:0]  handle_offset,
	input  logic              handle_valid,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ST_W-1:0]   status,
	output logic [OFS_W-1:0]  offset,
	output logic [BB_W-1:0]   size,
	output logic [SIG_W-1:0]  signature_out,
	output logic [CNT_W-1:0]  active_count
);

	localparam int NWORDS = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
	localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int BW     = $clog2(WORD_BITS);
	localparam int BW1    = $clog2(WORD_BITS + 1);
	localparam int IDW    = $clog2(NWORDS * WORD_BITS + 1);
	localparam int CW     = ((IDW > LIM_W) ? IDW : LIM_W) + 1;
	localparam int PW     = CW + BB_W;
	localparam int LIM_RST_I = (int'(BLOCK_LIMIT_RST) < CAPACITY) ?
		int'(BLOCK_LIMIT_RST) : CAPACITY;
	// id / WORD_BITS by reciprocal multiply, exact for ids below 2**CW
	localparam int QSH = CW + BW1;
	localparam int QPW = CW + QSH;
	localparam longint unsigned RECIP =
		((64'd1 << QSH) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS);

	typedef enum logic [9:0] {
		S_FMT   = 10'b00_0000_0001,
		S_IDLE  = 10'b00_0000_0010,
		S_ARD   = 10'b00_0000_0100,
		S_ACHK  = 10'b00_0000_1000,
		S_AMUL  = 10'b00_0001_0000,
		S_FDIV1 = 10'b00_0010_0000,
		S_FDIV2 = 10'b00_0100_0000,
		S_FRD   = 10'b00_1000_0000,
		S_FWR   = 10'b01_0000_0000,
		S_DONE  = 10'b10_0000_0000
	} state_t;

	state_t state_q;

	// configuration
	logic [BB_W-1:0]  bb_q;
	logic [LIM_W-1:0] lim_q;
	logic [LIM_W-1:0] rsv_q;

	// format limits, latched at start of a format pass
	logic [CW-1:0] fmt_rsv_q;
	logic [CW-1:0] fmt_lim_q;
	logic          fmt_reply_q;

	logic [AW-1:0]    scan_idx_q;
	logic [CW-1:0]    base_q;
	logic [CW-1:0]    id_q;
	logic [BW-1:0]    fb_q;
	logic [SIG_W-1:0] csig_q;
	logic [CNT_W-1:0] active_q;

	status_t          res_status_q;
	logic [OFS_W-1:0] res_offset_q;
	logic [BB_W-1:0]  res_size_q;
	logic [SIG_W-1:0] res_sig_q;

	logic             out_valid_q;
	status_t          out_status_q;
	logic [OFS_W-1:0] out_offset_q;
	logic [BB_W-1:0]  out_size_q;
	logic [SIG_W-1:0] out_sig_q;
	logic [CNT_W-1:0] out_active_q;

	logic                 ram_wr_en;
	logic [WORD_BITS-1:0] ram_wr_data;
	logic                 ram_rd_en;
	logic [AW-1:0]        ram_rd_addr;
	logic [WORD_BITS-1:0] ram_rdata;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic                 in_fire;
	logic                 free_ok;
	logic [CW-1:0]        eff_lim;
	logic                 last_word;
	logic                 found;
	logic [WORD_BITS-1:0] iso;
	logic [BW-1:0]        bidx;
	logic [WORD_BITS-1:0] fmt_mask;
	logic [BW1-1:0]       mask_lo;
	logic [BW1-1:0]       mask_hi;
	logic [CW-1:0]        d_lo;
	logic [CW-1:0]        d_hi;
	logic                 id_ok;
	logic [PW-1:0]        prod;
	logic [CW-1:0]        fid;
	logic [QPW-1:0]       qprod;
	logic [CW-1:0]        fword;
	logic [CW-1:0]        fbit;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign free_ok  = handle_valid && (handle_signature == caller_signature) && (bb_q != '0);
	assign eff_lim  = (CW'(lim_q) < CW'(CAPACITY)) ? CW'(lim_q) : CW'(CAPACITY);
	assign last_word = (scan_idx_q == AW'(NWORDS - 1));
	assign prod     = PW'(id_q) * PW'(bb_q);
	assign id_ok    = (div_rsp.quotient >= OFS_W'(rsv_q)) &&
		(div_rsp.quotient < OFS_W'(eff_lim));

	// word and bit position of a block id that passed the range check
	assign fid   = div_rsp.quotient[CW-1:0];
	assign qprod = QPW'(fid) * QPW'(RECIP);
	assign fword = qprod[QPW-1:QSH];
	assign fbit  = fid - fword * CW'(WORD_BITS);

	// lowest set bit of the word under scan
	always_comb begin
		found = |ram_rdata;
		iso   = ram_rdata & (~ram_rdata + WORD_BITS'(1));
		bidx  = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			if (iso[b]) begin
				bidx = bidx | BW'(b);
			end
		end
	end

	// free bits of one word: ids in [fmt_rsv, fmt_lim) relative to base
	always_comb begin
		d_lo = fmt_rsv_q - base_q;
		d_hi = fmt_lim_q - base_q;
		if (fmt_rsv_q <= base_q) begin
			mask_lo = '0;
		end else if (d_lo >= CW'(WORD_BITS)) begin
			mask_lo = BW1'(WORD_BITS);
		end else begin
			mask_lo = d_lo[BW1-1:0];
		end
		if (fmt_lim_q <= base_q) begin
			mask_hi = '0;
		end else if (d_hi >= CW'(WORD_BITS)) begin
			mask_hi = BW1'(WORD_BITS);
		end else begin
			mask_hi = d_hi[BW1-1:0];
		end
		for (int b = 0; b < WORD_BITS; b++) begin
			fmt_mask[b] = (BW1'(b) >= mask_lo) && (BW1'(b) < mask_hi);
		end
	end

	// bitmap access
	always_comb begin
		ram_rd_en   = 1'b0;
		ram_wr_en   = 1'b0;
		ram_wr_data = fmt_mask;
		ram_rd_addr = scan_idx_q;
		unique case (state_q)
			S_FMT: begin
				ram_wr_en = 1'b1;
			end
			S_ARD, S_FRD: begin
				ram_rd_en = 1'b1;
			end
			S_ACHK: begin
				// zero word: fetch the next one in the same cycle
				ram_rd_en   = !found && !last_word;
				ram_rd_addr = AW'(scan_idx_q + 1'b1);
				ram_wr_en   = found;
				ram_wr_data = ram_rdata & ~iso;
			end
			S_FWR: begin
				ram_wr_en   = 1'b1;
				ram_wr_data = ram_rdata | (WORD_BITS'(1) << fb_q);
			end
			default: ;
		endcase
	end

	// block id = offset / block_bytes
	always_comb begin
		div_req.start    = in_fire && (action == ACT_FREE) && free_ok;
		div_req.dividend = handle_offset;
		div_req.divisor  = bb_q;
	end

	bba_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	bba_ram #(
		.DEPTH (NWORDS),
		.WIDTH (WORD_BITS),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (scan_idx_q),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bb_q  <= BLOCK_BYTES_RST;
			lim_q <= BLOCK_LIMIT_RST;
			rsv_q <= RESERVED_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_BLOCK_BYTES: bb_q  <= cfg_wdata;
				REG_BLOCK_LIMIT: lim_q <= cfg_wdata[LIM_W-1:0];
				REG_RESERVED:    rsv_q <= cfg_wdata[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_FMT;
			fmt_rsv_q    <= CW'(RESERVED_RST);
			fmt_lim_q    <= CW'(LIM_RST_I);
			fmt_reply_q  <= 1'b0;
			scan_idx_q   <= '0;
			base_q       <= '0;
			id_q         <= '0;
			fb_q         <= '0;
			csig_q       <= '0;
			active_q     <= '0;
			res_status_q <= ST_OK;
			res_offset_q <= '0;
			res_size_q   <= '0;
			res_sig_q    <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
			out_offset_q <= '0;
			out_size_q   <= '0;
			out_sig_q    <= '0;
			out_active_q <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						csig_q       <= caller_signature;
						res_offset_q <= '0;
						res_size_q   <= '0;
						res_sig_q    <= '0;
						case (action)
							ACT_ALLOC: begin
								scan_idx_q <= '0;
								base_q     <= '0;
								state_q    <= S_ARD;
							end
							ACT_FREE: begin
								if (!handle_valid) begin
									res_status_q <= ST_IGNORED;
									state_q      <= S_DONE;
								end else if (handle_signature != caller_signature) begin
									res_status_q <= ST_BADSIG;
									state_q      <= S_DONE;
								end else if (bb_q == '0) begin
									res_status_q <= ST_BADID;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_FDIV1;
								end
							end
							ACT_FORMAT: begin
								fmt_rsv_q   <= CW'(rsv_q);
								fmt_lim_q   <= eff_lim;
								fmt_reply_q <= 1'b1;
								scan_idx_q  <= '0;
								base_q      <= '0;
								active_q    <= '0;
								state_q     <= S_FMT;
							end
							default: begin
								res_status_q <= ST_IGNORED;
								state_q      <= S_DONE;
							end
						endcase
					end
				end
				S_FMT: begin
					if (last_word) begin
						res_status_q <= ST_OK;
						state_q      <= fmt_reply_q ? S_DONE : S_IDLE;
					end else begin
						scan_idx_q <= AW'(scan_idx_q + 1'b1);
						base_q     <= base_q + CW'(WORD_BITS);
					end
				end
				S_ARD: begin
					state_q <= S_ACHK;
				end
				S_ACHK: begin
					if (found) begin
						id_q <= base_q + CW'(bidx);
						if (active_q != CNT_MAX) begin
							active_q <= active_q + 1'b1;
						end
						state_q <= S_AMUL;
					end else if (last_word) begin
						res_status_q <= ST_OOM;
						state_q      <= S_DONE;
					end else begin
						scan_idx_q <= AW'(scan_idx_q + 1'b1);
						base_q     <= base_q + CW'(WORD_BITS);
					end
				end
				S_AMUL: begin
					res_status_q <= ST_OK;
					res_offset_q <= prod[OFS_W-1:0];
					res_size_q   <= bb_q;
					res_sig_q    <= csig_q;
					state_q      <= S_DONE;
				end
				S_FDIV1: begin
					if (div_rsp.done) begin
						if (id_ok) begin
							state_q <= S_FDIV2;
						end else begin
							res_status_q <= ST_BADID;
							state_q      <= S_DONE;
						end
					end
				end
				S_FDIV2: begin
					scan_idx_q <= fword[AW-1:0];
					fb_q       <= fbit[BW-1:0];
					state_q    <= S_FRD;
				end
				S_FRD: begin
					state_q <= S_FWR;
				end
				S_FWR: begin
					// a double free leaves the bit set but still counts down
					if (active_q != '0) begin
						active_q <= active_q - 1'b1;
					end
					res_status_q <= ST_OK;
					state_q      <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_offset_q <= res_offset_q;
						out_size_q   <= res_size_q;
						out_sig_q    <= res_sig_q;
						out_active_q <= active_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign offset        = out_offset_q;
	assign size          = out_size_q;
	assign signature_out = out_sig_q;
	assign active_count  = out_active_q;

endmodule

// ===== hdl/bba_div.sv =====
// Restoring divider, one quotient bit per cycle.
module bba_div import bba_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int NW   = OFS_W;
	localparam int DW   = BB_W;
	localparam int CNTW = $clog2(NW + 1);

	logic [NW-1:0]   dvd_q;
	logic [DW-1:0]   dsr_q;
	logic [DW-1:0]   rem_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;

	logic [DW:0]   trial;
	logic          take;
	logic [DW:0]   diff;

	always_comb begin
		trial = {rem_q, dvd_q[NW-1]};
		take  = trial >= {1'b0, dsr_q};
		diff  = trial - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvd_q  <= '0;
			dsr_q  <= '0;
			rem_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (req.start) begin
					dvd_q  <= req.dividend;
					dsr_q  <= req.divisor;
					rem_q  <= '0;
					cnt_q  <= CNTW'(NW);
					busy_q <= 1'b1;
				end
			end else begin
				rem_q <= take ? diff[DW-1:0] : trial[DW-1:0];
				dvd_q <= {dvd_q[NW-2:0], take};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = done_q;
	assign rsp.quotient  = dvd_q;
	assign rsp.remainder = rem_q;

endmodule

// ===== hdl/bba_ram.sv =====
// Free bitmap store: one write port, one read port, registered read data.
module bba_ram import bba_pkg::*; #(
	parameter int DEPTH = CAPACITY_DEF / WORD_BITS_DEF,
	parameter int WIDTH = WORD_BITS_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
